>>> rtl/core/mexp_pkg.sv
// Shared types, token codes and lookup functions for the expression tokenizer.
// Used by every module of the block; depends on nothing else.
package mexp_pkg;

    // Default sizes, used as the parameter defaults of the top level.
    localparam int MAX_EXPR_LEN_DEF   = 4096;
    localparam int MAX_NAME_CHARS_DEF = 4;
    localparam int QUEUE_DEPTH_DEF    = 4;

    // Result field widths.
    localparam int KIND_W = 4;
    localparam int ID_W   = 4;
    localparam int POS_W  = 13;
    localparam int ERR_W  = 2;
    localparam int SLOTS  = 4;

    // Token kinds.
    localparam logic [KIND_W-1:0] K_NUM   = 4'd0;
    localparam logic [KIND_W-1:0] K_VAR   = 4'd1;
    localparam logic [KIND_W-1:0] K_CONST = 4'd2;
    localparam logic [KIND_W-1:0] K_FUNC  = 4'd3;
    localparam logic [KIND_W-1:0] K_PLUS  = 4'd4;
    localparam logic [KIND_W-1:0] K_MINUS = 4'd5;
    localparam logic [KIND_W-1:0] K_STAR  = 4'd6;
    localparam logic [KIND_W-1:0] K_SLASH = 4'd7;
    localparam logic [KIND_W-1:0] K_CARET = 4'd8;
    localparam logic [KIND_W-1:0] K_LPAR  = 4'd9;
    localparam logic [KIND_W-1:0] K_RPAR  = 4'd10;
    localparam logic [KIND_W-1:0] K_END   = 4'd11;
    localparam logic [KIND_W-1:0] K_ERR   = 4'd12;

    // Error codes.
    localparam logic [ERR_W-1:0] E_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] E_NUMBER  = 2'd1;
    localparam logic [ERR_W-1:0] E_IDENT   = 2'd2;
    localparam logic [ERR_W-1:0] E_INVALID = 2'd3;

    // Constant ids.
    localparam logic [ID_W-1:0] ID_PI = 4'd0;
    localparam logic [ID_W-1:0] ID_E  = 4'd1;

    // Function names, first character in the lowest byte, zero padded.
    localparam int NUM_FUNCS = 14;
    localparam logic [31:0] FUNC_WORDS [NUM_FUNCS] = '{
        32'h006E6973, 32'h00736F63, 32'h006E6174,
        32'h6E697361, 32'h736F6361, 32'h6E617461,
        32'h686E6973, 32'h68736F63, 32'h686E6174,
        32'h00676F6C, 32'h00006E6C, 32'h74727173,
        32'h00736261, 32'h00707865
    };

    // One result, without the last-of-run flag.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  span;
        logic              implicit;
        logic [ERR_W-1:0]  err;
    } t_tok;

    // All results caused by one input byte.
    typedef struct packed {
        logic [2:0]           count;
        t_tok [SLOTS-1:0]     slot;
    } t_bundle;

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
    } t_match;

    // Matches a zero-padded name word against the variable, constants and functions.
    function automatic t_match lookup_name(input logic [63:0] word);
        t_match m;
        m = '0;
        if (word == 64'h78) begin
            m = '{hit: 1'b1, kind: K_VAR, id: '0};
        end else if (word == 64'h6970) begin
            m = '{hit: 1'b1, kind: K_CONST, id: ID_PI};
        end else if (word == 64'h65) begin
            m = '{hit: 1'b1, kind: K_CONST, id: ID_E};
        end else begin
            for (int k = 0; k < NUM_FUNCS; k++) begin
                if (word == {32'h0, FUNC_WORDS[k]}) begin
                    m = '{hit: 1'b1, kind: K_FUNC, id: ID_W'(k)};
                end
            end
        end
        return m;
    endfunction

    // Operator character to token kind; anything else gives the error kind.
    function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        unique case (c)
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_SLASH;
            8'h5E:   k = K_CARET;
            8'h28:   k = K_LPAR;
            8'h29:   k = K_RPAR;
            default: k = K_ERR;
        endcase
        return k;
    endfunction

    // A token that can be followed by an implied multiply.
    function automatic logic is_opening(input logic [KIND_W-1:0] k);
        return (k == K_NUM) || (k == K_VAR) || (k == K_CONST) || (k == K_RPAR);
    endfunction

    // A token that an implied multiply may precede.
    function automatic logic is_closing(input logic [KIND_W-1:0] k);
        return (k == K_NUM) || (k == K_VAR) || (k == K_CONST) || (k == K_FUNC)
            || (k == K_LPAR);
    endfunction

endpackage

>>> rtl/core/mexp_front.sv
// Scanner front end: accepts one byte or end mark a cycle while the queue is not full, and classifies it.
// Builds the bundle of up to four results that the byte completes; uses mexp_pkg.
module mexp_front
    import mexp_pkg::*;
#(
    parameter int MAX_EXPR_LEN   = MAX_EXPR_LEN_DEF,
    parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_mode,
    input  logic [7:0] i_char,
    input  logic    i_full,
    output logic    o_ready,
    output logic    o_push,
    output t_bundle o_bundle
);

    localparam int IW = $clog2(MAX_EXPR_LEN + 1);
    localparam int NW = 8 * MAX_NAME_CHARS;
    localparam logic [IW-1:0] IDX_MAX = IW'(MAX_EXPR_LEN);

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_NUM  = 2'd1,
        S_NAME = 2'd2,
        S_ERR  = 2'd3
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [IW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   r_start, n_start;
    logic            r_dot, n_dot;
    logic            r_digit, n_digit;
    logic [NW-1:0]   r_name, n_name;
    logic            r_long, n_long;
    logic            r_prev, n_prev;

    logic            accept;
    logic            is_dig, is_alp, is_sp, is_dot;
    logic [KIND_W-1:0] c_kind;
    t_match          match;
    logic [IW-1:0]   run_len;
    logic [IW-1:0]   idx_inc;
    logic [POS_W-1:0] pos_idx, pos_start, span_run, span_dot2;
    logic            handled, dot2, do_finish, f_err, fin_ok, prev1, start_char;
    logic [KIND_W-1:0] f_kind;
    logic [ID_W-1:0] f_id;
    t_tok            cand [SLOTS];
    logic [SLOTS-1:0] cand_v;
    logic [2:0]      cnt;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // Character classes.
    assign is_dig = (i_char >= 8'h30) && (i_char <= 8'h39);
    assign is_alp = ((i_char >= 8'h61) && (i_char <= 8'h7A))
                 || ((i_char >= 8'h41) && (i_char <= 8'h5A));
    assign is_sp  = (i_char == 8'h20) || ((i_char >= 8'h09) && (i_char <= 8'h0D));
    assign is_dot = (i_char == 8'h2E);
    assign c_kind = op_kind(i_char);

    // Name lookup and run geometry.
    assign match     = lookup_name(64'(r_name));
    assign run_len   = r_idx - r_start;
    assign idx_inc   = (r_idx < IDX_MAX) ? r_idx + 1'b1 : r_idx;
    assign pos_idx   = POS_W'(r_idx);
    assign pos_start = POS_W'(r_start);
    assign span_run  = POS_W'(run_len);
    assign span_dot2 = POS_W'(idx_inc - r_start);

    // Decide how the pending run and the new byte combine.
    always_comb begin
        handled = 1'b0;
        dot2    = 1'b0;
        if (!i_mode && r_phase == S_NUM && (is_dig || is_dot)) begin
            handled = 1'b1;
            dot2    = is_dot && r_dot;
        end
        if (!i_mode && r_phase == S_NAME && (is_alp || is_dig)) begin
            handled = 1'b1;
        end
        do_finish = ((r_phase == S_NUM) || (r_phase == S_NAME)) && !handled;
        if (r_phase == S_NUM) begin
            f_err  = !r_digit;
            f_kind = K_NUM;
            f_id   = '0;
        end else begin
            f_err  = !(match.hit && !r_long);
            f_kind = match.kind;
            f_id   = match.id;
        end
        fin_ok     = !(do_finish && f_err);
        prev1      = (do_finish && !f_err) ? is_opening(f_kind) : r_prev;
        start_char = !i_mode && (r_phase != S_ERR) && !handled && fin_ok;
    end

    // Candidate results in emission order.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            cand[i] = '0;
        end
        cand_v = '0;

        // Implied multiply before the finished run.
        cand_v[0]        = do_finish && !f_err && r_prev && is_closing(f_kind);
        cand[0].kind     = K_STAR;
        cand[0].pos      = pos_start;
        cand[0].implicit = 1'b1;

        // Finished run, its error, or a second dot inside a number.
        cand_v[1] = do_finish || dot2;
        if (dot2) begin
            cand[1].kind = K_ERR;
            cand[1].pos  = pos_start;
            cand[1].span = span_dot2;
            cand[1].err  = E_NUMBER;
        end else if (f_err) begin
            cand[1].kind = K_ERR;
            cand[1].pos  = pos_start;
            cand[1].span = span_run;
            cand[1].err  = (r_phase == S_NUM) ? E_NUMBER : E_IDENT;
        end else begin
            cand[1].kind = f_kind;
            cand[1].id   = f_id;
            cand[1].pos  = pos_start;
            cand[1].span = span_run;
        end

        // Implied multiply before a left parenthesis.
        cand_v[2]        = start_char && !is_sp && !is_dig && !is_dot && !is_alp
                        && (c_kind == K_LPAR) && prev1;
        cand[2].kind     = K_STAR;
        cand[2].pos      = pos_idx;
        cand[2].implicit = 1'b1;

        // Operator, invalid character, or the end token.
        if (i_mode) begin
            cand_v[3]    = (r_phase != S_ERR) && fin_ok;
            cand[3].kind = K_END;
            cand[3].pos  = pos_idx;
        end else begin
            cand_v[3]    = start_char && !is_sp && !is_dig && !is_dot && !is_alp;
            cand[3].kind = c_kind;
            cand[3].pos  = pos_idx;
            cand[3].span = POS_W'(1);
            cand[3].err  = (c_kind == K_ERR) ? E_INVALID : E_NONE;
        end
    end

    // Pack the valid candidates into the low slots of the bundle.
    always_comb begin
        o_bundle = '0;
        cnt      = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (cand_v[i]) begin
                o_bundle.slot[cnt[1:0]] = cand[i];
                cnt = cnt + 3'd1;
            end
        end
        o_bundle.count = cnt;
        o_push         = accept && (cnt != 3'd0);
    end

    // Next scanner state.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_start = r_start;
        n_dot   = r_dot;
        n_digit = r_digit;
        n_name  = r_name;
        n_long  = r_long;
        n_prev  = r_prev;
        if (i_mode) begin
            n_phase = S_IDLE;
            n_idx   = '0;
            n_start = '0;
            n_dot   = 1'b0;
            n_digit = 1'b0;
            n_name  = '0;
            n_long  = 1'b0;
            n_prev  = 1'b0;
        end else if (r_phase == S_ERR) begin
            n_idx = idx_inc;
        end else begin
            n_idx = idx_inc;
            if (dot2) begin
                n_phase = S_ERR;
            end else if (handled && r_phase == S_NUM) begin
                n_digit = r_digit | is_dig;
                n_dot   = r_dot | is_dot;
            end else if (handled) begin
                // Another name character: store it or mark the name as too long.
                if (r_idx >= IDX_MAX || run_len >= IW'(MAX_NAME_CHARS)) begin
                    n_long = 1'b1;
                end else begin
                    for (int k = 0; k < MAX_NAME_CHARS; k++) begin
                        if (run_len == IW'(k)) begin
                            n_name[8*k +: 8] = i_char;
                        end
                    end
                end
            end else begin
                if (do_finish) begin
                    n_phase = f_err ? S_ERR : S_IDLE;
                    n_prev  = prev1;
                end
                if (fin_ok) begin
                    n_dot   = 1'b0;
                    n_digit = 1'b0;
                    n_name  = '0;
                    n_long  = 1'b0;
                    n_start = r_idx;
                    if (is_sp) begin
                        n_phase = S_IDLE;
                    end else if (is_dig || is_dot) begin
                        n_phase = S_NUM;
                        n_digit = is_dig;
                        n_dot   = is_dot;
                    end else if (is_alp) begin
                        n_phase = S_NAME;
                        if (r_idx >= IDX_MAX) begin
                            n_long = 1'b1;
                        end else begin
                            n_name[7:0] = i_char;
                        end
                    end else if (c_kind == K_ERR) begin
                        n_phase = S_ERR;
                    end else begin
                        n_phase = S_IDLE;
                        n_prev  = (c_kind == K_RPAR);
                    end
                end
            end
        end
    end

    // Scanner state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_IDLE;
            r_idx   <= '0;
            r_start <= '0;
            r_dot   <= 1'b0;
            r_digit <= 1'b0;
            r_name  <= '0;
            r_long  <= 1'b0;
            r_prev  <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_start <= n_start;
            r_dot   <= n_dot;
            r_digit <= n_digit;
            r_name  <= n_name;
            r_long  <= n_long;
            r_prev  <= n_prev;
        end
    end

endmodule

>>> rtl/core/mexp_queue.sv
// Short queue of result bundles between the scanner and the output stage.
// Register-based ring with occupancy count; uses mexp_pkg.
module mexp_queue
    import mexp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_bundle o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_bundle       r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/core/mexp_back.sv
// Output stage: walks the head bundle one result at a time into an output register.
// Marks the final result of each bundle as last; uses mexp_pkg.
module mexp_back
    import mexp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_bundle i_head,
    input  logic    i_empty,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_tok    o_tok,
    output logic    o_last
);

    logic [1:0] r_sel;
    logic       r_valid;
    t_tok       r_tok;
    logic       r_last;
    logic       load, sel_last;

    assign load     = !i_empty && (!r_valid || i_ready);
    assign sel_last = ({1'b0, r_sel} == (i_head.count - 3'd1));
    assign o_pop    = load && sel_last;
    assign o_valid  = r_valid;
    assign o_tok    = r_tok;
    assign o_last   = r_last;

    // Slot selector and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sel   <= sel_last ? 2'd0 : r_sel + 2'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok  <= i_head.slot[r_sel];
            r_last <= sel_last;
        end
    end

endmodule

>>> rtl/core/math_expression_tokenizer.sv
// Arithmetic expression tokenizer top level: scanner, bundle queue, output stage.
// Depends on mexp_pkg, mexp_front, mexp_queue and mexp_back.
//
// Usage: the slave stream carries one byte of expression text per beat in
// tdata, with tuser low for a character and high for the end of the
// expression. The master stream returns tokens: kind, name id, position,
// length, implied-multiply flag and error code; tlast marks the final token
// caused by one input beat. A beat may cause no token (whitespace, bytes
// inside a number or name, bytes after an error).
// Throughput: one input beat per cycle while the queue has room. The
// scanner decides all tokens of a byte combinationally and writes them as
// one queue entry; the output register drains one token per cycle while
// the receiver is ready, and the queue absorbs the bursts of a byte that
// completes more than one token.
// The tokens of a beat are written to a queue entry and then to the output
// register. When the receiver stalls, tokens wait in the output register and
// the queue; s_axis_tready drops once the queue holds QUEUE_DEPTH entries.
// Reset clears the scanner state, position counter and queue; no clearing
// pass is needed and the block accepts beats as soon as reset is released.
module math_expression_tokenizer
    import mexp_pkg::*;
#(
    parameter int MAX_EXPR_LEN   = MAX_EXPR_LEN_DEF,
    parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  logic [0:0]  i_s_axis_tuser,   // [0] mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [3:0] name_id, [16:4] position,
                                          // [29:17] span_length, [31:30] error_code
    output logic [4:0]  o_m_axis_tuser,   // [3:0] token_kind, [4] is_implicit
    output logic        o_m_axis_tlast
);

    logic    full, empty, push, pop;
    t_bundle bundle, head;
    t_tok    tok;

    mexp_front #(
        .MAX_EXPR_LEN   (MAX_EXPR_LEN),
        .MAX_NAME_CHARS (MAX_NAME_CHARS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_mode   (i_s_axis_tuser[0]),
        .i_char   (i_s_axis_tdata),
        .i_full   (full),
        .o_ready  (o_s_axis_tready),
        .o_push   (push),
        .o_bundle (bundle)
    );

    mexp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (bundle),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    mexp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_tok   (tok),
        .o_last  (o_m_axis_tlast)
    );

    // Pack the token onto the master stream.
    assign o_m_axis_tdata = {tok.err, tok.span, tok.pos, tok.id};
    assign o_m_axis_tuser = {tok.implicit, tok.kind};

endmodule
